FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the dated rate table.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/drtf_pkg.sv
// Types, constants and date helpers for the dated rate table.
// Depends on nothing; every other RTL file of the block but assert_macros.svh uses it.
package drtf_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 7;
   localparam int DAY_W    = 7;
   localparam int KEY_W    = 23;
   localparam int RATE_W   = 32;
   localparam int AMT_W    = 31;
   localparam int PROD_W   = 42;
   localparam int STATUS_W = 3;

   // Radix of the gather tree is 2**RADIX_BITS inputs per node.
   localparam int RADIX_BITS = 5;

   localparam logic [AMT_W-1:0]   MAX_AMOUNT_RST = 31'd4096000;
   localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_FIRST    = 7'd1;
   localparam logic [MONTH_W-1:0] MONTH_LAST     = 7'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB      = 7'd2;
   localparam logic [DAY_W-1:0]   DAY_FIRST      = 7'd1;
   localparam logic [DAY_W-1:0]   DAY_FEB_LEAP   = 7'd29;

   // Multiplicative inverse of 25 modulo 2**14. A year is a multiple of 25
   // exactly when year times this inverse, kept to 14 bits, is at most 655.
   localparam logic [YEAR_W-1:0]  INV25      = 14'd7209;
   localparam logic [YEAR_W-1:0]  DIV25_MAX  = 14'd655;

   typedef enum logic [STATUS_W-1:0] {
      STS_QUERY_OK   = 3'd0,
      STS_LOADED     = 3'd1,
      STS_BAD_DATE   = 3'd2,
      STS_NEGATIVE   = 3'd3,
      STS_TOO_LARGE  = 3'd4,
      STS_NO_DATA    = 3'd5,
      STS_TABLE_FULL = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic is_query;
      logic do_insert;
      logic do_overwrite;
   } cell_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [RATE_W-1:0] rate;
   } leaf_type;

   localparam int LEAF_W = $bits(leaf_type);

   function automatic int tree_levels(int depth);
      return ($clog2(depth) + RADIX_BITS - 1) / RADIX_BITS;
   endfunction

   function automatic logic [DAY_W-1:0] month_days(logic [3:0] m);
      logic [DAY_W-1:0] lim;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 7'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    lim = 7'd30;
         4'd2:                                       lim = 7'd28;
         default:                                    lim = 7'd0;
      endcase
      return lim;
   endfunction

   function automatic logic date_ok(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                    logic [DAY_W-1:0] d);
      logic [YEAR_W-1:0] inv_prod;
      logic              div25;
      logic              leap;
      logic [DAY_W-1:0]  lim;
      inv_prod = YEAR_W'(y * INV25);
      div25    = (inv_prod <= DIV25_MAX);
      leap     = (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
      lim      = month_days(m[3:0]);
      if ((m == MONTH_FEB) && leap) begin
         lim = DAY_FEB_LEAP;
      end
      return (y <= YEAR_MAX) && (m >= MONTH_FIRST) && (m <= MONTH_LAST) &&
             (d >= DAY_FIRST) && (d <= lim);
   endfunction

   function automatic logic [KEY_W-1:0] make_key(logic [YEAR_W-1:0] y,
                                                 logic [MONTH_W-1:0] m,
                                                 logic [DAY_W-1:0] d);
      return {y, m[3:0], d[4:0]};
   endfunction

endpackage

FILE: hw/rtl/drtf_req_if.sv
// Request channel of the dated rate table: valid/ready plus one item.
// Depends on drtf_pkg for the field widths.
interface drtf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [drtf_pkg::YEAR_W-1:0]         year;
   logic [drtf_pkg::MONTH_W-1:0]        month;
   logic [drtf_pkg::DAY_W-1:0]          day;
   logic signed [drtf_pkg::RATE_W-1:0]  value;

   modport source (output valid, output req_type, output year, output month,
                   output day, output value, input ready);
   modport sink   (input valid, input req_type, input year, input month,
                   input day, input value, output ready);
endinterface

FILE: hw/rtl/drtf_rsp_if.sv
// Response channel of the dated rate table: valid/ready plus one result.
// Depends on drtf_pkg for the field widths.
interface drtf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [drtf_pkg::STATUS_W-1:0]       status;
   logic signed [drtf_pkg::RATE_W-1:0]  rate_used;
   logic signed [drtf_pkg::PROD_W-1:0]  product;

   modport source (output valid, output status, output rate_used, output product,
                   input ready);
   modport sink   (input valid, input status, input rate_used, input product,
                   output ready);
endinterface

FILE: hw/rtl/drtf_cell.sv
// One slot of the sorted table: holds a key and a rate, compares against
// the item key, and shifts in its left neighbor on insert. Uses drtf_pkg.
module drtf_cell (
   input  logic                          clock,
   input  logic                          occupied,
   input  drtf_pkg::cell_ctl_type        ctl,
   input  logic [drtf_pkg::KEY_W-1:0]    item_key,
   input  logic [drtf_pkg::RATE_W-1:0]   item_rate,
   input  logic [drtf_pkg::KEY_W-1:0]    prev_key,
   input  logic [drtf_pkg::RATE_W-1:0]   prev_rate,
   input  logic                          prev_ge,
   input  logic                          next_le,
   output logic [drtf_pkg::KEY_W-1:0]    key,
   output logic [drtf_pkg::RATE_W-1:0]   rate,
   output logic                          le,
   output logic                          ge,
   output drtf_pkg::leaf_type            leaf
);

   logic [drtf_pkg::KEY_W-1:0]  key_ff,  key_in;
   logic [drtf_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic                        eq;
   logic                        hit;

   always_comb begin
      le  = occupied && (key_ff <= item_key);
      ge  = !occupied || (key_ff >= item_key);
      eq  = occupied && (key_ff == item_key);
      // The occupied cells are sorted, so the last cell at or below the
      // item key is the floor entry.
      hit = le && !next_le;

      if (ctl.is_query) begin
         leaf.hit  = hit;
         leaf.rate = hit ? rate_ff : '0;
      end else begin
         leaf.hit  = eq;
         leaf.rate = '0;
      end

      key_in  = key_ff;
      rate_in = rate_ff;
      if (ctl.do_overwrite && eq) begin
         rate_in = item_rate;
      end else if (ctl.do_insert && ge) begin
         if (prev_ge) begin
            key_in  = prev_key;
            rate_in = prev_rate;
         end else begin
            key_in  = item_key;
            rate_in = item_rate;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      rate_ff <= rate_in;
   end

   assign key  = key_ff;
   assign rate = rate_ff;

endmodule

FILE: hw/rtl/drtf_gather.sv
// Registered OR tree that collects the one flagged cell's leaf into a
// single root, 2**RADIX_BITS inputs per node. Uses drtf_pkg.
module drtf_gather #(
   parameter int DEPTH = 1024
) (
   input  logic               clock,
   input  drtf_pkg::leaf_type leaf [DEPTH],
   output drtf_pkg::leaf_type root
);

   localparam int RB     = drtf_pkg::RADIX_BITS;
   localparam int RADIX  = 1 << RB;
   localparam int LEVELS = drtf_pkg::tree_levels(DEPTH);
   localparam int LW     = drtf_pkg::LEAF_W;

   function automatic int level_nodes(int l);
      return (DEPTH + (1 << (RB * l)) - 1) >> (RB * l);
   endfunction

   function automatic int level_base(int l);
      int s;
      s = 0;
      for (int j = 1; j < l; j++) begin
         s = s + level_nodes(j);
      end
      return s;
   endfunction

   localparam int TOTAL = level_base(LEVELS + 1);

   logic [LW-1:0] node_in [TOTAL];
   logic [LW-1:0] node_ff [TOTAL];

   genvar l, n;
   generate
      for (l = 1; l <= LEVELS; l++) begin : g_level
         for (n = 0; n < level_nodes(l); n++) begin : g_node
            localparam int FIRST = n * RADIX;
            localparam int AVAIL = level_nodes(l - 1) - FIRST;
            localparam int NCH   = (AVAIL < RADIX) ? AVAIL : RADIX;
            logic [LW-1:0] acc;
            if (l == 1) begin : g_leaves
               always_comb begin
                  acc = '0;
                  for (int c = 0; c < NCH; c++) begin
                     acc = acc | leaf[FIRST + c];
                  end
               end
            end else begin : g_inner
               always_comb begin
                  acc = '0;
                  for (int c = 0; c < NCH; c++) begin
                     acc = acc | node_ff[level_base(l - 1) + FIRST + c];
                  end
               end
            end
            assign node_in[level_base(l) + n] = acc;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign root = node_ff[TOTAL-1];

endmodule

FILE: hw/rtl/drtf_scale.sv
// Three-stage signed scaler: magnitude of the rate, multiply by the amount,
// then drop fraction bits, saturate and restore the sign. Uses drtf_pkg.
module drtf_scale #(
   parameter int FRAC_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [drtf_pkg::RATE_W-1:0]   rate,
   input  logic [drtf_pkg::AMT_W-1:0]    amount,
   output logic                          done,
   output logic [drtf_pkg::PROD_W-1:0]   product
);

   localparam int MUL_W = drtf_pkg::RATE_W + drtf_pkg::AMT_W;
   localparam int PW    = drtf_pkg::PROD_W;
   localparam logic [MUL_W-1:0] SAT_LIM  = MUL_W'(1) << (PW - 1);
   localparam logic [PW-1:0]    POS_SAT  = {1'b0, {(PW-1){1'b1}}};
   localparam logic [PW-1:0]    NEG_SAT  = {1'b1, {(PW-1){1'b0}}};

   logic                          s0_valid_ff, s0_valid_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          done_ff,     done_in;
   logic [drtf_pkg::RATE_W-1:0]   mag_ff,      mag_in;
   logic [drtf_pkg::AMT_W-1:0]    amt_ff;
   logic                          neg0_ff, neg1_ff;
   logic [MUL_W-1:0]              prod_ff,     prod_in;
   logic [PW-1:0]                 product_ff,  product_in;
   logic [MUL_W-1:0]              shifted;

   always_comb begin
      s0_valid_in = start;
      s1_valid_in = s0_valid_ff;
      done_in     = s1_valid_ff;
      // The most negative rate gives 2**31, which still fits unsigned.
      mag_in      = rate[drtf_pkg::RATE_W-1] ? (~rate + drtf_pkg::RATE_W'(1)) : rate;
      prod_in     = MUL_W'(mag_ff) * MUL_W'(amt_ff);
      shifted     = prod_ff >> FRAC_BITS;
      if (neg1_ff) begin
         product_in = (shifted >= SAT_LIM) ? NEG_SAT : (~shifted[PW-1:0] + PW'(1));
      end else begin
         product_in = (shifted >= SAT_LIM) ? POS_SAT : shifted[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      amt_ff     <= amount;
      neg0_ff    <= rate[drtf_pkg::RATE_W-1];
      prod_ff    <= prod_in;
      neg1_ff    <= neg0_ff;
      product_ff <= product_in;
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

FILE: hw/rtl/dated_rate_table_floor_lookup.sv
// Dated rate table with floor lookup. Entries live sorted by date in a row of
// TABLE_DEPTH cells that all compare against the item's date at once; an
// insert shifts all the later cells one place together. The block works
// on one item at a time. A bad date, a negative amount or an amount above
// max_amount goes straight to the done state. Any other item passes the
// gather tree of L = ceil(log2(TABLE_DEPTH)/5) registered 32-input OR stages
// (2 at 1024 entries); a query that finds a rate then passes the three scaler
// stages: the rate magnitude, the multiply and the saturate. There is no
// clearing pass after reset: the entry count marks which cells hold data.
// The response sits in an output register; a held response stalls the
// hand-off of the next result, and no new item is taken while it waits.
`include "assert_macros.svh"

module dated_rate_table_floor_lookup #(
   parameter int TABLE_DEPTH = 1024,
   parameter int FRAC_BITS   = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   drtf_req_if.sink                     req_chan,
   drtf_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic [drtf_pkg::AMT_W-1:0]   csr_wdata
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int LEVELS = drtf_pkg::tree_levels(TABLE_DEPTH);
   localparam int SCAN_W = $clog2(LEVELS + 1);

   drtf_pkg::state_type            state_ff, state_in;
   logic [SCAN_W-1:0]              scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [drtf_pkg::AMT_W-1:0]     max_amount_ff, max_amount_in;

   logic                           item_query_ff, item_query_in;
   logic [drtf_pkg::KEY_W-1:0]     item_key_ff, item_key_in;
   logic [drtf_pkg::RATE_W-1:0]    item_value_ff, item_value_in;
   drtf_pkg::status_type           status_ff, status_in;
   logic [drtf_pkg::RATE_W-1:0]    res_rate_ff, res_rate_in;
   logic [drtf_pkg::PROD_W-1:0]    res_product_ff, res_product_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   drtf_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [drtf_pkg::RATE_W-1:0]    rsp_rate_ff, rsp_rate_in;
   logic [drtf_pkg::PROD_W-1:0]    rsp_product_ff, rsp_product_in;

   logic                           req_beat;
   logic                           date_good;
   logic                           table_full;
   logic                           scale_start;
   logic                           scale_done;
   logic [drtf_pkg::PROD_W-1:0]    scale_product;
   drtf_pkg::cell_ctl_type         ctl;
   drtf_pkg::leaf_type             root;

   logic [drtf_pkg::KEY_W-1:0]     key_w  [TABLE_DEPTH];
   logic [drtf_pkg::RATE_W-1:0]    rate_w [TABLE_DEPTH];
   logic                           le_w   [TABLE_DEPTH];
   logic                           ge_w   [TABLE_DEPTH];
   drtf_pkg::leaf_type             leaf_w [TABLE_DEPTH];

   // Row of cells; each one sees its left neighbor's entry and ge flag and
   // its right neighbor's le flag.
   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_slot
         logic                        occ;
         logic [drtf_pkg::KEY_W-1:0]  prev_key;
         logic [drtf_pkg::RATE_W-1:0] prev_rate;
         logic                        prev_ge;
         logic                        next_le;

         assign occ = (count_ff > CNT_W'(i));

         if (i == 0) begin : g_first
            assign prev_key  = '0;
            assign prev_rate = '0;
            assign prev_ge   = 1'b0;
         end else begin : g_inner
            assign prev_key  = key_w[i-1];
            assign prev_rate = rate_w[i-1];
            assign prev_ge   = ge_w[i-1];
         end

         if (i == TABLE_DEPTH - 1) begin : g_last
            assign next_le = 1'b0;
         end else begin : g_mid
            assign next_le = le_w[i+1];
         end

         drtf_cell u_cell (
            .clock     (clock),
            .occupied  (occ),
            .ctl       (ctl),
            .item_key  (item_key_ff),
            .item_rate (item_value_ff),
            .prev_key  (prev_key),
            .prev_rate (prev_rate),
            .prev_ge   (prev_ge),
            .next_le   (next_le),
            .key       (key_w[i]),
            .rate      (rate_w[i]),
            .le        (le_w[i]),
            .ge        (ge_w[i]),
            .leaf      (leaf_w[i])
         );
      end
   endgenerate

   drtf_gather #(
      .DEPTH (TABLE_DEPTH)
   ) u_gather (
      .clock (clock),
      .leaf  (leaf_w),
      .root  (root)
   );

   drtf_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock   (clock),
      .reset   (reset),
      .start   (scale_start),
      .rate    (root.rate),
      .amount  (item_value_ff[drtf_pkg::AMT_W-1:0]),
      .done    (scale_done),
      .product (scale_product)
   );

   assign req_chan.ready = (state_ff == drtf_pkg::ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign date_good      = drtf_pkg::date_ok(req_chan.year, req_chan.month, req_chan.day);
   assign table_full     = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      state_in       = state_ff;
      scan_cnt_in    = scan_cnt_ff;
      count_in       = count_ff;
      max_amount_in  = csr_we ? csr_wdata : max_amount_ff;
      item_query_in  = item_query_ff;
      item_key_in    = item_key_ff;
      item_value_in  = item_value_ff;
      status_in      = status_ff;
      res_rate_in    = res_rate_ff;
      res_product_in = res_product_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_product_in = rsp_product_ff;
      scale_start    = 1'b0;
      ctl.is_query     = item_query_ff;
      ctl.do_insert    = 1'b0;
      ctl.do_overwrite = 1'b0;

      case (state_ff)
         drtf_pkg::ST_IDLE: begin
            if (req_beat) begin
               item_query_in  = req_chan.req_type;
               item_key_in    = drtf_pkg::make_key(req_chan.year, req_chan.month,
                                                   req_chan.day);
               item_value_in  = req_chan.value;
               res_rate_in    = '0;
               res_product_in = '0;
               scan_cnt_in    = '0;
               if (!date_good) begin
                  status_in = drtf_pkg::STS_BAD_DATE;
                  state_in  = drtf_pkg::ST_DONE;
               end else if (req_chan.req_type && req_chan.value[drtf_pkg::RATE_W-1]) begin
                  status_in = drtf_pkg::STS_NEGATIVE;
                  state_in  = drtf_pkg::ST_DONE;
               end else if (req_chan.req_type &&
                            (req_chan.value[drtf_pkg::AMT_W-1:0] > max_amount_ff)) begin
                  status_in = drtf_pkg::STS_TOO_LARGE;
                  state_in  = drtf_pkg::ST_DONE;
               end else begin
                  state_in = drtf_pkg::ST_SCAN;
               end
            end
         end
         drtf_pkg::ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + SCAN_W'(1);
            if (scan_cnt_ff == SCAN_W'(LEVELS - 1)) begin
               state_in = drtf_pkg::ST_RESOLVE;
            end
         end
         drtf_pkg::ST_RESOLVE: begin
            state_in = drtf_pkg::ST_DONE;
            if (!item_query_ff) begin
               // For a load the root flag says the date is already present.
               if (root.hit) begin
                  ctl.do_overwrite = 1'b1;
                  status_in        = drtf_pkg::STS_LOADED;
               end else if (table_full) begin
                  status_in = drtf_pkg::STS_TABLE_FULL;
               end else begin
                  ctl.do_insert = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  status_in     = drtf_pkg::STS_LOADED;
               end
            end else if (!root.hit) begin
               status_in = drtf_pkg::STS_NO_DATA;
            end else begin
               status_in   = drtf_pkg::STS_QUERY_OK;
               res_rate_in = root.rate;
               scale_start = 1'b1;
               state_in    = drtf_pkg::ST_SCALE;
            end
         end
         drtf_pkg::ST_SCALE: begin
            if (scale_done) begin
               res_product_in = scale_product;
               state_in       = drtf_pkg::ST_DONE;
            end
         end
         drtf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_rate_in    = res_rate_ff;
               rsp_product_in = res_product_ff;
               state_in       = drtf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = drtf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= drtf_pkg::ST_IDLE;
         scan_cnt_ff   <= '0;
         count_ff      <= '0;
         max_amount_ff <= drtf_pkg::MAX_AMOUNT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         count_ff      <= count_in;
         max_amount_ff <= max_amount_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_query_ff  <= item_query_in;
      item_key_ff    <= item_key_in;
      item_value_ff  <= item_value_in;
      status_ff      <= status_in;
      res_rate_ff    <= res_rate_in;
      res_product_ff <= res_product_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_product_ff <= rsp_product_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.rate_used = rsp_rate_ff;
   assign rsp_chan.product   = rsp_product_ff;

   `ASSERT_IMPLIES(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `ASSERT_NEXT(a_insert_grows, clock, reset, ctl.do_insert, count_ff == $past(count_ff) + CNT_W'(1))
   `ASSERT_IMPLIES(a_error_zero, clock, reset, rsp_valid_ff && (rsp_status_ff != drtf_pkg::STS_QUERY_OK), (rsp_rate_ff == '0) && (rsp_product_ff == '0))

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the dated rate table with floor lookup.
// Depends on drtf_pkg, the drtf_req_if and drtf_rsp_if interfaces and the
// dated_rate_table_floor_lookup top level; a local table model predicts every beat.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   TABLE_DEPTH = 1024;
   localparam int   FRAC_BITS   = 12;
   localparam int   YEAR_W      = drtf_pkg::YEAR_W;
   localparam int   MONTH_W     = drtf_pkg::MONTH_W;
   localparam int   DAY_W       = drtf_pkg::DAY_W;
   localparam int   KEY_W       = drtf_pkg::KEY_W;
   localparam int   RATE_W      = drtf_pkg::RATE_W;
   localparam int   AMT_W       = drtf_pkg::AMT_W;
   localparam int   PROD_W      = drtf_pkg::PROD_W;
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_QUERY   = 1'b1;
   localparam logic signed [RATE_W-1:0] RATE_MAX = 32'sh7FFFFFFF;
   localparam logic signed [RATE_W-1:0] RATE_MIN = 32'sh80000000;
   localparam logic signed [RATE_W-1:0] ONE      = 32'sd4096;
   localparam logic [AMT_W-1:0]         AMT_MAX  = 31'h7FFFFFFF;
   localparam logic [63:0] PROD_POS_SAT = 64'h1FF_FFFF_FFFF;
   localparam logic [63:0] PROD_NEG_SAT = 64'h200_0000_0000;

   typedef struct {
      logic [KEY_W-1:0]         key;
      logic signed [RATE_W-1:0] rate;
   } rate_entry_type;

   typedef struct {
      drtf_pkg::status_type     status;
      logic signed [RATE_W-1:0] rate;
      logic signed [PROD_W-1:0] product;
   } rate_reply_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [AMT_W-1:0] csr_wdata;

   drtf_req_if req_chan();
   drtf_rsp_if rsp_chan();

   dated_rate_table_floor_lookup #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // Model of the table contents, kept sorted by key.
   rate_entry_type   rate_book[$];
   logic [AMT_W-1:0] max_amount_model = drtf_pkg::MAX_AMOUNT_RST;
   rate_reply_type   expected_results[$];

   int  fail_count      = 0;
   int  results_checked = 0;
   int  loads_sent      = 0;
   int  queries_sent    = 0;
   bit  tx_gaps         = 1'b1;
   bit  rx_stalls       = 1'b1;
   int  hold_left       = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned days_in(int unsigned y, int unsigned m);
      case (m)
         2: return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
      return y <= 9999 && m >= 1 && m <= 12 && d >= 1 && d <= days_in(y, m);
   endfunction

   // Applies one accepted item to the table model and returns its reply.
   function automatic rate_reply_type apply_item(logic kind, logic [YEAR_W-1:0] y,
                                                 logic [MONTH_W-1:0] m,
                                                 logic [DAY_W-1:0] d,
                                                 logic signed [RATE_W-1:0] v);
      rate_reply_type    r;
      rate_entry_type    e;
      logic [KEY_W-1:0]  key;
      logic [RATE_W-1:0] rbits;
      logic [63:0]       mag;
      int                pos;
      r.status  = drtf_pkg::STS_QUERY_OK;
      r.rate    = '0;
      r.product = '0;
      if (!date_valid(y, m, d)) begin
         r.status = drtf_pkg::STS_BAD_DATE;
         return r;
      end
      key = {y, m[3:0], d[4:0]};
      pos = 0;
      while (pos < rate_book.size() && rate_book[pos].key < key) pos++;
      if (kind == REQ_LOAD) begin
         if (pos < rate_book.size() && rate_book[pos].key == key) begin
            rate_book[pos].rate = v;
         end else if (rate_book.size() >= TABLE_DEPTH) begin
            r.status = drtf_pkg::STS_TABLE_FULL;
            return r;
         end else begin
            e.key  = key;
            e.rate = v;
            rate_book.insert(pos, e);
         end
         r.status = drtf_pkg::STS_LOADED;
         return r;
      end
      if (v[RATE_W-1]) begin
         r.status = drtf_pkg::STS_NEGATIVE;
         return r;
      end
      if ($unsigned(v) > {1'b0, max_amount_model}) begin
         r.status = drtf_pkg::STS_TOO_LARGE;
         return r;
      end
      if (!(pos < rate_book.size() && rate_book[pos].key == key)) begin
         if (pos == 0) begin
            r.status = drtf_pkg::STS_NO_DATA;
            return r;
         end
         pos--;
      end
      // Work on the magnitude so that the shift truncates toward zero.
      rbits = rate_book[pos].rate;
      mag   = rbits[RATE_W-1] ? {32'd0, -rbits} : {32'd0, rbits};
      mag   = (mag * {33'd0, v[30:0]}) >> FRAC_BITS;
      if (rbits[RATE_W-1]) begin
         if (mag > PROD_NEG_SAT) mag = PROD_NEG_SAT;
         r.product = -mag[PROD_W-1:0];
      end else begin
         if (mag > PROD_POS_SAT) mag = PROD_POS_SAT;
         r.product = mag[PROD_W-1:0];
      end
      r.rate = rbits;
      return r;
   endfunction

   // Sends one item, with a random gap ahead of it when gaps are enabled.
   task automatic send_item(logic kind, logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                            logic [DAY_W-1:0] d, logic signed [RATE_W-1:0] v);
      int gap;
      if (tx_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.year     <= y;
      req_chan.month    <= m;
      req_chan.day      <= d;
      req_chan.value    <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_results.push_back(apply_item(kind, y, m, d, v));
      if (kind == REQ_QUERY) queries_sent++;
      else loads_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_max_amount(logic [AMT_W-1:0] limit);
      wait_for_results();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= limit;
      @(negedge clock);
      csr_we <= 1'b0;
      max_amount_model = limit;
   endtask

   function automatic void pick_date(output logic [YEAR_W-1:0] y,
                                     output logic [MONTH_W-1:0] m,
                                     output logic [DAY_W-1:0] d);
      int unsigned    sel;
      int unsigned    yy;
      int unsigned    mm;
      rate_entry_type e;
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
         y = YEAR_W'($urandom);
         m = MONTH_W'($urandom);
         d = DAY_W'($urandom);
      end else if (sel <= 2) begin
         // Calendar edges: century years, the year limits, ends of months.
         case ($urandom_range(0, 7))
            0: yy = 0;
            1: yy = 1900;
            2: yy = 2000;
            3: yy = 2100;
            4: yy = 2400;
            5: yy = 9999;
            6: yy = 10000;
            default: yy = 2023;
         endcase
         y = YEAR_W'(yy);
         m = ($urandom_range(0, 3) == 0) ? MONTH_W'($urandom_range(0, 13))
                                         : drtf_pkg::MONTH_FEB;
         d = ($urandom_range(0, 7) == 0) ? 7'd0 : DAY_W'($urandom_range(27, 32));
      end else if (sel <= 7 && rate_book.size() != 0) begin
         e = rate_book[$urandom_range(0, rate_book.size() - 1)];
         y = e.key[22:9];
         m = {3'd0, e.key[8:5]};
         d = {2'd0, e.key[4:0]};
      end else begin
         yy = $urandom_range(0, 1) ? $urandom_range(1990, 2030) : $urandom_range(0, 9999);
         mm = $urandom_range(1, 12);
         y  = YEAR_W'(yy);
         m  = MONTH_W'(mm);
         d  = DAY_W'($urandom_range(1, days_in(yy, mm)));
      end
   endfunction

   function automatic logic signed [RATE_W-1:0] pick_value(logic kind);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (kind == REQ_LOAD) begin
         if (sel < 5) return $urandom;
         return $urandom_range(0, 16384) - 8192;
      end
      if (sel == 0) return {1'b1, 31'($urandom)};
      if (sel == 1 && max_amount_model != AMT_MAX)
         return {1'b0, 31'($urandom_range(max_amount_model + 1, AMT_MAX))};
      if (sel == 2) return {1'b0, max_amount_model};
      return {1'b0, 31'($urandom_range(0, max_amount_model))};
   endfunction

   task automatic send_random_item();
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      logic               kind;
      kind = ($urandom_range(0, 99) < 55) ? REQ_QUERY : REQ_LOAD;
      pick_date(y, m, d);
      send_item(kind, y, m, d, pick_value(kind));
   endtask

   // Empty table first: no data and a negative amount, then every way a date can be malformed.
   task automatic test_bad_dates();
      send_item(REQ_QUERY, 14'd2024, 7'd3, 7'd1, ONE);
      send_item(REQ_QUERY, 14'd2024, 7'd3, 7'd1, -32'sd1);
      send_item(REQ_LOAD, 14'd10000, 7'd1, 7'd1, ONE);
      send_item(REQ_LOAD, 14'd16383, 7'd12, 7'd31, ONE);
      send_item(REQ_QUERY, 14'd2024, 7'd0, 7'd10, ONE);
      send_item(REQ_LOAD, 14'd2024, 7'd13, 7'd1, ONE);
      send_item(REQ_QUERY, 14'd2024, 7'd127, 7'd127, -32'sd1);
      send_item(REQ_LOAD, 14'd2023, 7'd4, 7'd31, ONE);
      send_item(REQ_LOAD, 14'd1900, 7'd2, 7'd29, ONE);
      send_item(REQ_LOAD, 14'd2023, 7'd2, 7'd29, ONE);
      send_item(REQ_LOAD, 14'd2000, 7'd2, 7'd30, ONE);
      send_item(REQ_QUERY, 14'd2024, 7'd1, 7'd0, ONE);
   endtask

   task automatic test_load_and_lookup();
      send_item(REQ_LOAD, 14'd0, 7'd2, 7'd29, ONE);
      send_item(REQ_LOAD, 14'd2000, 7'd2, 7'd29, RATE_MIN);
      send_item(REQ_LOAD, 14'd2024, 7'd2, 7'd29, RATE_MAX);
      send_item(REQ_LOAD, 14'd9999, 7'd12, 7'd31, -32'sd1);
      send_item(REQ_LOAD, 14'd2000, 7'd2, 7'd29, 32'sd8192);
      send_item(REQ_QUERY, 14'd2000, 7'd2, 7'd29, ONE);
      send_item(REQ_QUERY, 14'd2010, 7'd6, 7'd15, 32'sd4096000);
      // A tiny negative product must truncate to zero, not to minus one.
      send_item(REQ_QUERY, 14'd9999, 7'd12, 7'd31, 32'sd1);
   endtask

   task automatic test_amount_checks();
      set_max_amount('0);
      send_item(REQ_QUERY, 14'd2010, 7'd6, 7'd15, 32'sd0);
      send_item(REQ_QUERY, 14'd2010, 7'd6, 7'd15, 32'sd1);
      set_max_amount(AMT_MAX);
      send_item(REQ_QUERY, 14'd2024, 7'd12, 7'd31, RATE_MAX);
      send_item(REQ_LOAD, 14'd2025, 7'd1, 7'd1, RATE_MIN);
      send_item(REQ_QUERY, 14'd2025, 7'd6, 7'd1, RATE_MAX);
      send_item(REQ_QUERY, 14'd0, 7'd1, 7'd1, 32'sd0);
   endtask

   task automatic test_random(int count, logic [AMT_W-1:0] limit, bit gaps);
      set_max_amount(limit);
      tx_gaps   = gaps;
      rx_stalls = gaps;
      repeat (count) send_random_item();
   endtask

   // The receiver holds off for a long stretch while items keep coming, so
   // the output register fills and the input stalls.
   task automatic test_backpressure();
      wait_for_results();
      tx_gaps   = 1'b0;
      hold_left = 300;
      repeat (12) send_random_item();
      wait_for_results();
      tx_gaps = 1'b1;
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_LOAD;
      req_chan.year      = '0;
      req_chan.month     = '0;
      req_chan.day       = '0;
      req_chan.value     = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bad_dates();
      test_load_and_lookup();
      test_amount_checks();
      test_random(125, AMT_MAX, 1'b1);
      test_random(125, 31'($urandom_range(1, 32'h7FFFFFFE)), 1'b1);
      test_backpressure();
      test_random(125, drtf_pkg::MAX_AMOUNT_RST, 1'b1);
      // The last stretch runs with no idling on either side.
      test_random(125, 31'd4096, 1'b0);
      wait_for_results();

      $display("Checked %0d result beats from %0d loads and %0d queries.",
               results_checked, loads_sent, queries_sent);
      $display("Covered malformed dates, amount limits, floor lookups and a long stall; %0s",
               $sformatf("%0d entries were held at the end.", rate_book.size()));
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d checks failed", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Receiver: random stall bursts, plus the long hold asked for by the
   // backpressure test, counted down here one cycle at a time.
   initial begin : ready_driver
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_checker
      rate_reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result beat: status %0d rate %0d product %0d",
                        rsp_chan.status, rsp_chan.rate_used, rsp_chan.product);
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.rate_used !== want.rate ||
                rsp_chan.product !== want.product) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("beat %0d mismatch: expected status %0d rate %0d product %0d",
                           results_checked, want.status, want.rate, want.product);
                  $display("   got status %0d rate %0d product %0d",
                           rsp_chan.status, rsp_chan.rate_used, rsp_chan.product);
               end
            end
            results_checked++;
         end
      end
   end

   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
